FILE: design/fvd_pkg.sv
// Shared types and constants for the frame energy voice detector.
package fvd_pkg;

   // Field and register widths
   localparam int SAMPLE_W    = 16;
   localparam int FRAME_LEN_W = 11;
   localparam int THRESH_W    = 31;
   localparam int MIN_W       = 13;
   localparam int COUNT_OUT_W = 13;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 31;

   // Default sizing of the block
   localparam int WINDOW_FRAMES_DEFAULT    = 1024;
   localparam int MAX_FRAME_LENGTH_DEFAULT = 1024;

   // Register values after reset
   localparam logic [FRAME_LEN_W-1:0] FRAME_LEN_RESET = FRAME_LEN_W'(160);
   localparam logic [THRESH_W-1:0]    THRESH_RESET    = THRESH_W'(53687);
   localparam logic [MIN_W-1:0]       MIN_RESET       = MIN_W'(10);

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_LENGTH = 2'd0,
      CSR_THRESHOLD    = 2'd1,
      CSR_MIN_SPEECH   = 2'd2
   } csr_index_type;

endpackage

FILE: design/fvd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fvd_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port (read returns old data on collision)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/frame_energy_voice_detector_core.sv
// Top level of the frame energy voice detector: framing, energy sum, speech window.
//
// Usage:
//  - req_* carries one signed 16-bit PCM sample per beat (valid/ready).
//  - rsp_* carries one result beat at each frame end: the frame's speech flag,
//    the number of speech frames in the last WINDOW_FRAMES frames and the
//    voice-present decision against the minimum speech frame count.
//  - csr_* writes a register by index: 0 frame length, 1 energy threshold
//    (raw squared-sample units), 2 minimum speech frames. Always ready.
//    Write registers only while the block is idle.
// Timing:
//  - One sample per cycle sustained while the result channel does not stall.
//    A three-register pipeline (square, accumulate, judge/window update): the
//    result of the sample that ends a frame passes through each in that order.
//  - The window's flag ring is a RAM read one slot ahead of its pointer, so
//    a frame may end on every sample.
// Reset: registers return to defaults, frame and window empty. The ring RAM
//  needs no clearing pass: a fill count marks slots not yet written as zero.
// Stall: while a result waits on rsp_ready the whole pipeline holds and
//  req_ready is low; a beat without a frame end moves whenever rsp is free.
module frame_energy_voice_detector_core #(
   parameter int WINDOW_FRAMES    = fvd_pkg::WINDOW_FRAMES_DEFAULT,
   parameter int MAX_FRAME_LENGTH = fvd_pkg::MAX_FRAME_LENGTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // sample channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [fvd_pkg::SAMPLE_W-1:0]   req_pcm_sample,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_frame_is_speech,
   output logic [fvd_pkg::COUNT_OUT_W-1:0]       rsp_speech_frame_count,
   output logic                                  rsp_voice_present,
   // configuration channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [fvd_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [fvd_pkg::CSR_DATA_W-1:0]        csr_data
);

   import fvd_pkg::*;

   localparam int POS_W   = $clog2(MAX_FRAME_LENGTH + 1);
   localparam int SQ_W    = 2 * SAMPLE_W - 1;
   localparam int SUM_W   = SQ_W + $clog2(MAX_FRAME_LENGTH);
   localparam int LIMIT_W = THRESH_W + POS_W;
   localparam int CMP_W   = (SUM_W > LIMIT_W) ? SUM_W : LIMIT_W;
   localparam int NCMP_W  = (FRAME_LEN_W > POS_W) ? FRAME_LEN_W : POS_W;
   localparam int PTR_W   = (WINDOW_FRAMES > 1) ? $clog2(WINDOW_FRAMES) : 1;
   localparam int CNT_W   = $clog2(WINDOW_FRAMES + 1);

   // Configuration registers
   logic [FRAME_LEN_W-1:0] frame_length_ff;
   logic [THRESH_W-1:0]    threshold_ff;
   logic [MIN_W-1:0]       min_frames_ff;

   // Derived frame length and energy limit
   logic [NCMP_W-1:0]  len_wide;
   logic [POS_W-1:0]   frame_len_n;
   logic [LIMIT_W-1:0] limit_in, limit_ff;

   // Pipeline
   logic                advance, accept;
   logic [SAMPLE_W-1:0] mag;
   logic [2*SAMPLE_W-1:0] square;
   logic                s1_valid_ff;
   logic [SQ_W-1:0]     sq_ff;
   logic [POS_W-1:0]    pos_ff, pos_new;
   logic [SUM_W-1:0]    sum_ff, sum_new, frame_sum_ff;
   logic                frame_end;
   logic                s2_valid_ff;

   // Window
   logic                fire, flag, old_flag, ring_full;
   logic [PTR_W-1:0]    ptr_ff, ptr_in;
   logic [CNT_W-1:0]    fill_ff, count_ff, count_in;
   logic                byp_ff, byp_data_ff;
   logic [0:0]          ring_rd_data;

   // Result register
   logic                   rsp_valid_ff, rsp_flag_ff, rsp_voice_ff;
   logic [COUNT_OUT_W-1:0] rsp_count_ff, count_out;

   // Register writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_length_ff <= FRAME_LEN_RESET;
         threshold_ff    <= THRESH_RESET;
         min_frames_ff   <= MIN_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FRAME_LENGTH: frame_length_ff <= csr_data[FRAME_LEN_W-1:0];
            CSR_THRESHOLD:    threshold_ff    <= csr_data[THRESH_W-1:0];
            CSR_MIN_SPEECH:   min_frames_ff   <= csr_data[MIN_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective frame length: zero acts as one, long lengths saturate
   assign len_wide = NCMP_W'(frame_length_ff);

   always_comb begin
      if (frame_length_ff == '0) begin
         frame_len_n = POS_W'(1);
      end else if (len_wide > NCMP_W'(MAX_FRAME_LENGTH)) begin
         frame_len_n = POS_W'(MAX_FRAME_LENGTH);
      end else begin
         frame_len_n = len_wide[POS_W-1:0];
      end
   end

   // Energy limit = threshold * length, registered off the config
   assign limit_in = LIMIT_W'(threshold_ff) * LIMIT_W'(frame_len_n);

   always_ff @(posedge clock) begin
      limit_ff <= limit_in;
   end

   // Handshake: the pipeline moves when the result register is free
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign accept    = req_valid && advance;

   // Stage 1: square of the sample magnitude
   assign mag    = req_pcm_sample[SAMPLE_W-1] ? (~req_pcm_sample + 1'b1) : req_pcm_sample;
   assign square = (2*SAMPLE_W)'(mag) * (2*SAMPLE_W)'(mag);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sq_ff <= square[SQ_W-1:0];
      end
   end

   // Stage 2: accumulate and detect the frame end
   assign sum_new   = sum_ff + SUM_W'(sq_ff);
   assign pos_new   = pos_ff + 1'b1;
   assign frame_end = (pos_new >= frame_len_n);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         sum_ff      <= '0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff && frame_end;
         if (s1_valid_ff) begin
            if (frame_end) begin
               pos_ff <= '0;
               sum_ff <= '0;
            end else begin
               pos_ff <= pos_new;
               sum_ff <= sum_new;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff && frame_end) begin
         frame_sum_ff <= sum_new;
      end
   end

   // Stage 3: judge the frame and update the speech window
   assign fire      = advance && s2_valid_ff;
   assign flag      = CMP_W'(frame_sum_ff) > CMP_W'(limit_ff);
   assign ring_full = (fill_ff == CNT_W'(WINDOW_FRAMES));
   assign old_flag  = ring_full && (byp_ff ? byp_data_ff : ring_rd_data[0]);
   assign count_in  = count_ff - CNT_W'(old_flag) + CNT_W'(flag);
   assign count_out = COUNT_OUT_W'(count_in);

   always_comb begin
      ptr_in = ptr_ff;
      if (fire) begin
         if (ptr_ff == PTR_W'(WINDOW_FRAMES - 1)) begin
            ptr_in = '0;
         end else begin
            ptr_in = ptr_ff + 1'b1;
         end
      end
   end

   // Ring RAM is read at the next pointer so the old flag is ready in time
   fvd_ram #(
      .WIDTH (1),
      .DEPTH (WINDOW_FRAMES)
   ) u_flag_ring (
      .clock   (clock),
      .wr_en   (fire),
      .wr_addr (ptr_ff),
      .wr_data (flag),
      .rd_addr (ptr_in),
      .rd_data (ring_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff   <= '0;
         fill_ff  <= '0;
         count_ff <= '0;
         byp_ff   <= 1'b0;
      end else begin
         ptr_ff <= ptr_in;
         // write and read on the same slot (one-frame window): forward the flag
         byp_ff <= fire && (ptr_in == ptr_ff);
         if (fire) begin
            count_ff <= count_in;
            if (!ring_full) begin
               fill_ff <= fill_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      byp_data_ff <= flag;
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_flag_ff  <= flag;
         rsp_count_ff <= count_out;
         rsp_voice_ff <= (count_out >= min_frames_ff);
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_frame_is_speech    = rsp_flag_ff;
   assign rsp_speech_frame_count = rsp_count_ff;
   assign rsp_voice_present      = rsp_voice_ff;

   // Checks
   a_count_le_fill : assert property (@(posedge clock) disable iff (reset)
      count_ff <= fill_ff)
      else $error("speech count exceeds frames seen");

   a_ptr_tracks_fill : assert property (@(posedge clock) disable iff (reset)
      !ring_full |-> (CNT_W'(ptr_ff) == fill_ff))
      else $error("ring pointer out of step with fill count");

   a_ptr_in_range : assert property (@(posedge clock) disable iff (reset)
      CNT_W'(ptr_ff) < CNT_W'(WINDOW_FRAMES))
      else $error("ring pointer beyond window");

   a_fire_gives_result : assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("frame end produced no result beat");

   a_pos_bounded : assert property (@(posedge clock) disable iff (reset)
      POS_W'(pos_ff) < POS_W'(MAX_FRAME_LENGTH))
      else $error("frame position beyond maximum length");

endmodule

FILE: test/frame_energy_voice_detector_core_tb.sv
// Self-checking testbench for frame_energy_voice_detector_core.
module frame_energy_voice_detector_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fvd_pkg::*;

   localparam int WINDOW      = WINDOW_FRAMES_DEFAULT;
   localparam int MAX_LEN     = MAX_FRAME_LENGTH_DEFAULT;
   localparam int PIPE_SLACK  = 8;
   localparam int RANDOM_GOAL = 200;
   localparam int WRAP_ITEMS  = 1100;
   // index past the register list, writes to it must be dropped
   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_SPARE = 2'd3;

   typedef struct packed {
      logic                   speech;
      logic [COUNT_OUT_W-1:0] count;
      logic                   present;
   } frame_verdict_type;

   // Tracks register values and window state, predicts one verdict per frame end
   class voice_scoreboard;
      logic [FRAME_LEN_W-1:0] frame_len_cfg;
      logic [THRESH_W-1:0]    threshold_cfg;
      logic [MIN_W-1:0]       min_frames_cfg;
      int unsigned            frame_fill;
      longint unsigned        frame_energy;
      bit                     flag_ring [WINDOW];
      int unsigned            ring_slot;
      int unsigned            window_count;
      frame_verdict_type      verdict_q [$];
      int unsigned            errors;

      function new();
         frame_len_cfg  = FRAME_LEN_RESET;
         threshold_cfg  = THRESH_RESET;
         min_frames_cfg = MIN_RESET;
         frame_fill     = 0;
         frame_energy   = 0;
         ring_slot      = 0;
         window_count   = 0;
         errors         = 0;
         foreach (flag_ring[i]) flag_ring[i] = 1'b0;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_FRAME_LENGTH: frame_len_cfg  = data[FRAME_LEN_W-1:0];
            CSR_THRESHOLD:    threshold_cfg  = data[THRESH_W-1:0];
            CSR_MIN_SPEECH:   min_frames_cfg = data[MIN_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_sample(logic signed [SAMPLE_W-1:0] value);
         int                level;
         int unsigned       len;
         longint unsigned   thresh;
         longint unsigned   limit;
         bit                speech;
         frame_verdict_type v;
         level = value;
         frame_energy += longint'(level * level);
         frame_fill++;
         // zero length acts as one, oversized lengths clamp
         len = (frame_len_cfg == 0) ? 1 : ((frame_len_cfg > MAX_LEN) ? MAX_LEN : frame_len_cfg);
         if (frame_fill < len) return;
         thresh = threshold_cfg;
         limit  = thresh * len;
         speech = frame_energy > limit;
         frame_fill   = 0;
         frame_energy = 0;
         // oldest flag leaves the window as the new one enters
         window_count = window_count - flag_ring[ring_slot] + speech;
         flag_ring[ring_slot] = speech;
         ring_slot = (ring_slot + 1) % WINDOW;
         v.speech  = speech;
         v.count   = COUNT_OUT_W'(window_count);
         v.present = window_count >= min_frames_cfg;
         verdict_q = {verdict_q, v};
      endfunction

      function void check_result(logic speech, logic [COUNT_OUT_W-1:0] count, logic present);
         frame_verdict_type v;
         if (verdict_q.size() == 0) begin
            $error("unexpected result beat: speech %0d count %0d present %0d",
                   speech, count, present);
            errors++;
            return;
         end
         v = verdict_q.pop_front();
         if (speech !== v.speech) begin
            $error("frame_is_speech: expected %0d, actual %0d", v.speech, speech);
            errors++;
         end
         if (count !== v.count) begin
            $error("speech_frame_count: expected %0d, actual %0d", v.count, count);
            errors++;
         end
         if (present !== v.present) begin
            $error("voice_present: expected %0d, actual %0d", v.present, present);
            errors++;
         end
      endfunction

      function int unsigned pending();
         return verdict_q.size();
      endfunction
   endclass

   logic                          clock          = 1'b0;
   logic                          reset          = 1'b1;
   logic                          req_valid      = 1'b0;
   logic                          req_ready;
   logic signed [SAMPLE_W-1:0]    req_pcm_sample = '0;
   logic                          rsp_valid;
   logic                          rsp_ready      = 1'b0;
   logic                          rsp_frame_is_speech;
   logic [COUNT_OUT_W-1:0]        rsp_speech_frame_count;
   logic                          rsp_voice_present;
   logic                          csr_valid      = 1'b0;
   logic                          csr_ready;
   logic [CSR_INDEX_W-1:0]        csr_index      = '0;
   logic [CSR_DATA_W-1:0]         csr_data       = '0;

   voice_scoreboard sb = new();
   bit              steady = 1'b0;
   int              random_items;

   frame_energy_voice_detector_core u_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_pcm_sample         (req_pcm_sample),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_frame_is_speech    (rsp_frame_is_speech),
      .rsp_speech_frame_count (rsp_speech_frame_count),
      .rsp_voice_present      (rsp_voice_present),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_data               (csr_data)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // result side backpressure, off during the steady stretch
   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(0, 99) >= 10);
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_frame_is_speech, rsp_speech_frame_count, rsp_voice_present);
   end

   // one sample beat, with an occasional gap ahead of it
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
      while (!steady && $urandom_range(0, 99) < 10) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_pcm_sample <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_sample(value);
   endtask

   // one register write beat
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_register(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // upper data bits are junk on purpose, the register keeps only its width
   task automatic set_frame_length(input int unsigned len);
      write_csr(CSR_FRAME_LENGTH, {20'($urandom), FRAME_LEN_W'(len)});
   endtask

   task automatic set_min_frames(input int unsigned count);
      write_csr(CSR_MIN_SPEECH, {18'($urandom), MIN_W'(count)});
   endtask

   // stop sending and let the pipeline empty out
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (PIPE_SLACK) @(posedge clock);
   endtask

   // random sample within +/- level, with the odd full-scale or silent one
   function automatic logic signed [SAMPLE_W-1:0] draw_sample(input int unsigned level);
      int pick;
      int v;
      pick = $urandom_range(0, 15);
      if (pick == 0) return 16'sh8000;
      if (pick == 1) return 16'sh7fff;
      if (pick == 2) return '0;
      v = int'($urandom_range(0, 2 * level)) - int'(level);
      if (v > 32767) v = 32767;
      return SAMPLE_W'(v);
   endfunction

   // threshold near the mean square of the chosen level, sometimes an extreme
   function automatic logic [THRESH_W-1:0] draw_threshold(input int unsigned level);
      longint unsigned base;
      int              pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return '0;
      if (pick == 1) return THRESH_W'($urandom);
      if (pick == 2) return THRESH_W'(1 << 30);
      base = longint'(level) * level / 3;
      base = base * $urandom_range(50, 200) / 100;
      if (base > 31'h7fffffff) base = 31'h7fffffff;
      return THRESH_W'(base);
   endfunction

   // minimum close to the current window count so both decisions show up
   function automatic int unsigned draw_min();
      int pick;
      int m;
      pick = $urandom_range(0, 9);
      if (pick == 0) return 0;
      if (pick == 1) return (1 << MIN_W) - 1;
      if (pick == 2) return $urandom_range(0, (1 << MIN_W) - 1);
      m = int'(sb.window_count) + int'($urandom_range(0, 6)) - 3;
      return (m < 0) ? 0 : m;
   endfunction

   initial begin
      int unsigned level;
      int unsigned burst;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // one frame on the reset settings, level close to the default threshold
      for (int i = 0; i < 160; i++) send_sample(draw_sample(400));
      settle();

      // zero length acts as one sample per frame, zero threshold and minimum
      set_frame_length(0);
      write_csr(CSR_THRESHOLD, '0);
      set_min_frames(0);
      send_sample(16'sh0000);
      send_sample(16'sh8000);
      send_sample(16'sh7fff);
      send_sample(16'sh0001);
      send_sample(16'shffff);
      send_sample(16'sh5555);
      send_sample(16'shaaaa);
      settle();

      // full-scale square sitting exactly on the threshold is not speech
      write_csr(CSR_THRESHOLD, THRESH_W'(1 << 30));
      set_min_frames((1 << MIN_W) - 1);
      send_sample(16'sh8000);
      send_sample(16'sh7fff);
      settle();

      // one below it is
      write_csr(CSR_THRESHOLD, THRESH_W'((1 << 30) - 1));
      send_sample(16'sh8000);
      send_sample(16'sh7fff);
      settle();

      // threshold at its maximum, write to the spare index is dropped
      write_csr(CSR_THRESHOLD, 31'h7fffffff);
      write_csr(CSR_INDEX_SPARE, CSR_DATA_W'($urandom));
      set_min_frames(1);
      send_sample(16'sh8000);
      settle();

      // length lowered while a frame is partly full: frame closes on the next beat
      set_frame_length(8);
      write_csr(CSR_THRESHOLD, 31'd1000);
      set_min_frames(2);
      send_sample(16'sh0028);
      send_sample(-16'sh0028);
      send_sample(16'sh0010);
      send_sample(16'sh0000);
      send_sample(16'sh0030);
      settle();
      set_frame_length(3);
      send_sample(-16'sh0020);
      settle();
      set_frame_length(4);
      for (int i = 0; i < 4; i++) send_sample(draw_sample(64));
      settle();

      // oversized length holds the frame open, then a short length closes it
      set_frame_length((1 << FRAME_LEN_W) - 1);
      write_csr(CSR_THRESHOLD, THRESH_W'((1 << 30) - $urandom_range(0, 1)));
      for (int i = 0; i < 20; i++)
         send_sample(($urandom_range(0, 7) != 0) ? 16'sh8000 : 16'sh7fff);
      settle();
      set_frame_length(1);
      send_sample(16'sh8000);
      settle();

      // long back-to-back run of one-sample frames so the window wraps
      steady = 1'b1;
      set_frame_length(1);
      write_csr(CSR_THRESHOLD, THRESH_W'(1 << 28));
      set_min_frames($urandom_range(200, 500));
      for (int i = 0; i < WRAP_ITEMS; i++) send_sample(draw_sample(32768));
      settle();
      steady = 1'b0;

      // random phases with fresh settings between them
      random_items = 0;
      while (random_items < RANDOM_GOAL) begin
         case ($urandom_range(0, 3))
            0:       level = 64;
            1:       level = 1024;
            2:       level = 8192;
            default: level = 32768;
         endcase
         if ($urandom_range(0, 9) < 7) begin
            case ($urandom_range(0, 19))
               0:       set_frame_length(0);
               1:       set_frame_length($urandom_range(9, 40));
               default: set_frame_length($urandom_range(1, 8));
            endcase
         end
         if ($urandom_range(0, 9) < 7) write_csr(CSR_THRESHOLD, draw_threshold(level));
         if ($urandom_range(0, 9) < 7) set_min_frames(draw_min());
         if ($urandom_range(0, 19) == 0) write_csr(CSR_INDEX_SPARE, CSR_DATA_W'($urandom));
         burst = $urandom_range(10, 80);
         for (int i = 0; i < burst; i++) begin
            // quiet and loud beats mixed so frames land on both sides of the threshold
            send_sample(draw_sample(($urandom_range(0, 1) != 0) ? level : level / 8));
            random_items++;
         end
         settle();
      end

      settle();
      if (sb.errors == 0)
         $display("** frame_energy_voice_detector_core: PASSED **");
      else
         $display("** frame_energy_voice_detector_core: FAILED **");
      $finish;
   end

   // watchdog
   initial begin
      #20ms;
      $display("** frame_energy_voice_detector_core: FAILED **");
      $finish;
   end

endmodule

FILE: sim.f
design/fvd_pkg.sv
design/fvd_ram.sv
design/frame_energy_voice_detector_core.sv
test/frame_energy_voice_detector_core_tb.sv
